/* design/pede_pkg.sv */
// Shared types, constants and arithmetic helpers for the palette dither core.
package pede_pkg;

	localparam int WORK_MIN = -4096;
	localparam int WORK_MAX = 8191;
	localparam int MAX_ROWS = 4096;

	typedef enum logic [0:0] {
		OP_PALETTE = 1'b0,
		OP_PIXEL   = 1'b1
	} opcode_bit_t;

	typedef struct packed {
		logic       opcode;
		logic [5:0] entry_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} item_t;

	typedef struct packed {
		logic [5:0] color_index;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       row_end;
		logic       frame_end;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH,
		ST_UPDATE,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_PALETTE = 2'd2
	} reg_index_t;

	// round k*e/16 to nearest, ties toward plus infinity
	function automatic logic signed [15:0] share16(logic signed [15:0] e, logic [2:0] k);
		logic signed [19:0] t;
		t = 20'(e) * 20'(signed'({1'b0, k})) + 20'sd8;
		return 16'(t >>> 4);
	endfunction

	// working value saturated to -256..511.9375 LSB
	function automatic logic signed [15:0] sat_work(logic signed [19:0] w);
		if (w < 20'(WORK_MIN)) return 16'(WORK_MIN);
		if (w > 20'(WORK_MAX)) return 16'(WORK_MAX);
		return 16'(w);
	endfunction

endpackage

/* design/pede_ram.sv */
// Single-port-write, single-port-read synchronous RAM with registered read data.
module pede_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* design/palette_error_diffusion_dither_core.sv */
// Top level of the Floyd-Steinberg palette dither core.
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+-------------------------
//  item      | in        | item_valid / item_ready  | item_t (palette write or pixel)
//  result    | out       | result_valid/result_ready| result_t (one per pixel)
//  config    | in        | APB psel/penable/pwrite  | width, height, palette count
//
// A palette write is taken while idle. A pixel goes through these steps in order:
// line buffer read, then one palette RAM read per entry through a two-stage
// distance pipeline, then the error update; a last pixel of a row that feeds
// a next row adds a flush step for the second line buffer write.
// Reset clears counters and carries; palette and line buffer RAMs are not cleared.
// A waiting result does not block the next request; a new result stalls
// the update step until the output register is free.
module palette_error_diffusion_dither_core #(
	parameter int MAX_WIDTH       = 1024,
	parameter int PALETTE_ENTRIES = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pede_pkg::item_t     item,
	output logic                result_valid,
	input  logic                result_ready,
	output pede_pkg::result_t   result,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import pede_pkg::*;

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int PW = $clog2(PALETTE_ENTRIES);

	// configuration registers
	logic [10:0] width_q;
	logic [12:0] height_q;
	logic [6:0]  pcount_q;

	state_t state_q, state_d;

	logic [AW-1:0] col_q;
	logic [11:0]   row_q;
	logic [AW-1:0] flush_addr_q;
	logic signed [15:0] rc_q  [3];
	logic signed [15:0] bp0_q [3];
	logic signed [15:0] bp1_q [3];
	logic signed [15:0] flush_q [3];
	logic [7:0]         pix_q [3];
	logic signed [15:0] work_q [3];

	// search pipeline
	logic [8:0]    nxt_q;
	logic          v1_q, v2_s2;
	logic [PW-1:0] i1_q, i2_s2;
	logic [29:0]   sq_s2 [3];
	logic [23:0]   col_s2;
	logic [PW-1:0] best_idx_q;
	logic [31:0]   best_d_q;
	logic [23:0]   best_col_q;

	result_t result_q;
	logic    result_valid_q;

	// memory ports
	logic          pal_we, pal_re;
	logic [PW-1:0] pal_waddr, pal_raddr;
	logic [23:0]   pal_rdata;
	logic          lb_we, lb_re;
	logic [AW-1:0] lb_waddr;
	logic [47:0]   lb_wdata, lb_rdata;

	logic accept, issue, done, go, last_col, last_row;
	logic [14:0] ew;
	logic [13:0] eh;
	logic [8:0]  ne;
	logic signed [15:0] err [3];
	logic signed [15:0] s7 [3], s3 [3], s5 [3], s1 [3];
	logic signed [15:0] lbv [3];
	logic [31:0] dist_sum;

	pede_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES), .AW(PW)) u_palette (
		.clk, .we(pal_we), .waddr(pal_waddr), .wdata({item.red, item.green, item.blue}),
		.re(pal_re), .raddr(pal_raddr), .rdata(pal_rdata)
	);

	pede_ram #(.WIDTH(48), .DEPTH(MAX_WIDTH), .AW(AW)) u_line (
		.clk, .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
		.re(lb_re), .raddr(col_q), .rdata(lb_rdata)
	);

	// effective frame sizes and palette count, clamped to their legal ranges
	always_comb begin
		if (width_q == 11'd0) ew = 15'd1;
		else if (15'(width_q) > 15'(MAX_WIDTH)) ew = 15'(MAX_WIDTH);
		else ew = 15'(width_q);
		if (height_q == 13'd0) eh = 14'd1;
		else if (14'(height_q) > 14'(MAX_ROWS)) eh = 14'(MAX_ROWS);
		else eh = 14'(height_q);
		if (pcount_q == 7'd0) ne = 9'd1;
		else if (9'(pcount_q) > 9'(PALETTE_ENTRIES)) ne = 9'(PALETTE_ENTRIES);
		else ne = 9'(pcount_q);
	end

	assign last_col = (15'(col_q) + 15'd1) >= ew;
	assign last_row = (14'(row_q) + 14'd1) >= eh;
	assign accept   = item_valid && item_ready;
	assign issue    = (state_q == ST_SEARCH) && (nxt_q < ne);
	assign done     = v2_s2 && (9'(i2_s2) == ne - 9'd1);
	assign go       = !result_valid_q || result_ready;
	assign dist_sum = 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			lbv[c] = (row_q != 12'd0) ? signed'(lb_rdata[47-16*c -: 16]) : 16'sd0;
			err[c] = work_q[c] - signed'(16'({4'd0, best_col_q[23-8*c -: 8], 4'd0}));
			s7[c]  = share16(err[c], 3'd7);
			s3[c]  = share16(err[c], 3'd3);
			s5[c]  = share16(err[c], 3'd5);
			s1[c]  = share16(err[c], 3'd1);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (accept && item.opcode == OP_PIXEL) state_d = ST_LOAD;
			ST_LOAD:   state_d = ST_SEARCH;
			ST_SEARCH: if (done) state_d = ST_UPDATE;
			ST_UPDATE: if (go) state_d = (last_col && !last_row) ? ST_FLUSH : ST_IDLE;
			ST_FLUSH:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		item_ready = (state_q == ST_IDLE);
		pal_we     = accept && item.opcode == OP_PALETTE &&
		             (32'(item.entry_index) < PALETTE_ENTRIES);
		pal_waddr  = PW'(item.entry_index);
		pal_re     = (state_q == ST_LOAD) || issue;
		pal_raddr  = (state_q == ST_LOAD) ? '0 : nxt_q[PW-1:0];
		lb_re      = accept && item.opcode == OP_PIXEL;
		lb_we      = 1'b0;
		lb_waddr   = col_q - AW'(1);
		lb_wdata   = {bp0_q[0] + s3[0], bp0_q[1] + s3[1], bp0_q[2] + s3[2]};
		case (state_q)
			ST_UPDATE: lb_we = go && !last_row && (col_q != '0);
			ST_FLUSH: begin
				lb_we    = 1'b1;
				lb_waddr = flush_addr_q;
				lb_wdata = {flush_q[0], flush_q[1], flush_q[2]};
			end
			default: lb_we = 1'b0;
		endcase
	end

	// APB
	assign pready = 1'b1;
	always_comb begin
		case (reg_index_t'(paddr[3:2]))
			REG_WIDTH:   prdata = 32'(width_q);
			REG_HEIGHT:  prdata = 32'(height_q);
			REG_PALETTE: prdata = 32'(pcount_q);
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 13'd1;
			pcount_q <= 7'd64;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_index_t'(paddr[3:2]))
				REG_WIDTH:   width_q  <= pwdata[10:0];
				REG_HEIGHT:  height_q <= pwdata[12:0];
				REG_PALETTE: pcount_q <= pwdata[6:0];
				default:     ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			col_q          <= '0;
			row_q          <= '0;
			v1_q           <= 1'b0;
			v2_s2          <= 1'b0;
			nxt_q          <= '0;
			result_valid_q <= 1'b0;
			for (int c = 0; c < 3; c++) begin
				rc_q[c]  <= '0;
				bp0_q[c] <= '0;
				bp1_q[c] <= '0;
			end
		end else begin
			state_q <= state_d;
			v1_q    <= (state_q == ST_LOAD) || issue;
			v2_s2   <= v1_q;
			if (state_q == ST_LOAD) nxt_q <= 9'd1;
			else if (issue) nxt_q <= nxt_q + 9'd1;
			if (result_ready) result_valid_q <= 1'b0;
			if (state_q == ST_UPDATE && go) begin
				result_valid_q <= 1'b1;
				for (int c = 0; c < 3; c++) begin
					rc_q[c] <= last_col ? 16'sd0 : s7[c];
					if (last_row) begin
						bp0_q[c] <= '0;
						bp1_q[c] <= '0;
					end else begin
						bp0_q[c] <= last_col ? 16'sd0 : bp1_q[c] + s5[c];
						bp1_q[c] <= last_col ? 16'sd0 : s1[c];
					end
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? 12'd0 : row_q + 12'd1;
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q[0] <= item.red;
			pix_q[1] <= item.green;
			pix_q[2] <= item.blue;
		end
		if (state_q == ST_LOAD) begin
			for (int c = 0; c < 3; c++) begin
				work_q[c] <= sat_work(20'(signed'({8'd0, pix_q[c], 4'd0})) +
				                      20'(rc_q[c]) + 20'(lbv[c]));
			end
		end
		i1_q <= (state_q == ST_LOAD) ? '0 : nxt_q[PW-1:0];
		if (v1_q) begin
			for (int c = 0; c < 3; c++) begin
				sq_s2[c] <= 30'((32'(work_q[c]) - 32'({pal_rdata[23-8*c -: 8], 4'd0})) *
				                (32'(work_q[c]) - 32'({pal_rdata[23-8*c -: 8], 4'd0})));
			end
			col_s2 <= pal_rdata;
			i2_s2  <= i1_q;
		end
		// strict less-than keeps the first minimum
		if (v2_s2 && (i2_s2 == '0 || dist_sum < best_d_q)) begin
			best_d_q   <= dist_sum;
			best_idx_q <= i2_s2;
			best_col_q <= col_s2;
		end
		if (state_q == ST_UPDATE && go) begin
			result_q.color_index <= 6'(best_idx_q);
			result_q.out_red     <= best_col_q[23:16];
			result_q.out_green   <= best_col_q[15:8];
			result_q.out_blue    <= best_col_q[7:0];
			result_q.row_end     <= last_col;
			result_q.frame_end   <= last_col && last_row;
			flush_addr_q         <= col_q;
			for (int c = 0; c < 3; c++) begin
				flush_q[c] <= bp1_q[c] + s5[c];
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;
endmodule
